@@ rtl/core/bpc_pkg.sv @@
// bpc_pkg: shared types, event codes, register indexes and reset values
// for the button press classifier; no dependencies
package bpc_pkg;

    localparam int unsigned TIME_W      = 32;
    localparam int unsigned LONG_W      = 16;
    localparam int unsigned DEBOUNCE_W  = 8;
    localparam int unsigned GAP_W       = 16;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned IN_DATA_W   = 40;
    localparam int unsigned OUT_DATA_W  = 8;

    // event codes on the result item
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } t_event;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HIGH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_GAP_MS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SINGLE_ENABLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_ENABLE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_ENABLE   = 3'd6;

    // press count saturates here
    localparam logic [1:0] COUNT_MAX = 2'd2;

    typedef struct packed {
        logic                  active_high;
        logic [LONG_W-1:0]     long_press_ms;
        logic [DEBOUNCE_W-1:0] debounce_ms;
        logic [GAP_W-1:0]      double_gap_ms;
        logic                  single_enable;
        logic                  double_enable;
        logic                  long_enable;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        active_high:   1'b1,
        long_press_ms: 16'd1000,
        debounce_ms:   8'd50,
        double_gap_ms: 16'd300,
        single_enable: 1'b1,
        double_enable: 1'b1,
        long_enable:   1'b1
    };

endpackage

@@ rtl/core/button_press_classifier.sv @@
// button_press_classifier: top level, classifies polled button samples into
// single, double and long press events; depends on bpc_pkg
//
// Each input item is one poll of a push button: the raw pin level and a
// millisecond time stamp (wrapping modulo 2^32). Every item yields exactly one
// result item, in order: the event code (none, single, double, long) and
// whether the pin level counts as pressed under the configured polarity.
// The block takes one item per clock cycle while the result side does not stall;
// an accepted item is loaded into the input register, then the classify stage
// updates the press tracking state and loads the result register, from which
// the result is offered on the output.
// The press tracking state closes its loop within that one classify stage,
// which is what sets the one-item-per-cycle figure. A held result does not
// block intake while the input register is free. Configuration registers are
// written through the plain write port and must only change while no items
// are in flight; writes to unknown indexes are ignored.
module button_press_classifier (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input items
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [bpc_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [0] pin_level, [32:1] now_ms, rest zero
    // result items
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [bpc_pkg::OUT_DATA_W-1:0]     m_axis_tdata   // [1:0] event_res, [2] pressed, rest zero
);

    // configuration registers
    bpc_pkg::t_cfg r_cfg;

    // input register
    logic                            r_in_valid;
    logic                            r_in_level;
    logic [bpc_pkg::TIME_W-1:0]      r_in_now;

    // press tracking state
    logic                            r_held;
    logic [bpc_pkg::TIME_W-1:0]      r_press_stamp;
    logic [bpc_pkg::TIME_W-1:0]      r_release_stamp;
    logic                            r_event_fired;
    logic [1:0]                      r_press_count;

    logic                            n_held;
    logic [bpc_pkg::TIME_W-1:0]      n_press_stamp;
    logic [bpc_pkg::TIME_W-1:0]      n_release_stamp;
    logic                            n_event_fired;
    logic [1:0]                      n_press_count;

    // result register
    logic                            r_out_valid;
    bpc_pkg::t_event                 r_out_event;
    logic                            r_out_pressed;

    bpc_pkg::t_event                 n_event;
    logic                            pressed;
    logic                            advance;
    logic                            fire;
    logic [bpc_pkg::TIME_W-1:0]      held_time;
    logic [bpc_pkg::TIME_W-1:0]      press_len;
    logic [bpc_pkg::TIME_W-1:0]      gap_time;
    logic [bpc_pkg::TIME_W-1:0]      rel_stamp;
    logic [1:0]                      cnt_after;

    // result register frees when empty or taken this cycle
    assign advance       = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    assign pressed = (r_in_level == r_cfg.active_high);

    // time differences, all modulo 2^32
    assign held_time = r_in_now - r_press_stamp;
    assign rel_stamp = r_held ? r_in_now : r_release_stamp;
    assign press_len = rel_stamp - r_press_stamp;
    assign gap_time  = r_in_now - rel_stamp;
    assign cnt_after = (r_held && (r_press_count < bpc_pkg::COUNT_MAX))
                     ? r_press_count + 2'd1 : r_press_count;

    always_comb begin
        n_held          = r_held;
        n_press_stamp   = r_press_stamp;
        n_release_stamp = r_release_stamp;
        n_event_fired   = r_event_fired;
        n_press_count   = r_press_count;
        n_event         = bpc_pkg::EV_NONE;

        if (r_event_fired) begin
            // wait for release, then clear everything
            if (!pressed) begin
                n_held          = 1'b0;
                n_press_stamp   = '0;
                n_release_stamp = '0;
                n_event_fired   = 1'b0;
                n_press_count   = '0;
            end
        end else if (pressed) begin
            if (!r_held) begin
                // new press begins
                n_press_stamp   = r_in_now;
                n_release_stamp = '0;
                n_held          = 1'b1;
            end else if (r_cfg.long_enable && (r_press_count == 2'd0) &&
                         (held_time >= {16'd0, r_cfg.long_press_ms})) begin
                n_event       = bpc_pkg::EV_LONG;
                n_event_fired = 1'b1;
            end
        end else begin
            // released, or still idle after a release
            n_release_stamp = rel_stamp;
            n_press_count   = cnt_after;
            n_held          = 1'b0;
            if (cnt_after != 2'd0) begin
                if (press_len <= {24'd0, r_cfg.debounce_ms}) begin
                    // too short: bounce, drop the whole sequence
                    n_held          = 1'b0;
                    n_press_stamp   = '0;
                    n_release_stamp = '0;
                    n_event_fired   = 1'b0;
                    n_press_count   = '0;
                end else if (r_cfg.single_enable &&
                             (!r_cfg.double_enable ||
                              (gap_time > {16'd0, r_cfg.double_gap_ms}))) begin
                    n_event       = bpc_pkg::EV_SINGLE;
                    n_event_fired = 1'b1;
                end else if (r_cfg.double_enable &&
                             (cnt_after >= bpc_pkg::COUNT_MAX)) begin
                    n_event       = bpc_pkg::EV_DOUBLE;
                    n_event_fired = 1'b1;
                end
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= bpc_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bpc_pkg::REG_ACTIVE_HIGH:   r_cfg.active_high   <= i_cfg_data[0];
                bpc_pkg::REG_LONG_PRESS_MS: r_cfg.long_press_ms <= i_cfg_data;
                bpc_pkg::REG_DEBOUNCE_MS:   r_cfg.debounce_ms   <=
                    i_cfg_data[bpc_pkg::DEBOUNCE_W-1:0];
                bpc_pkg::REG_DOUBLE_GAP_MS: r_cfg.double_gap_ms <= i_cfg_data;
                bpc_pkg::REG_SINGLE_ENABLE: r_cfg.single_enable <= i_cfg_data[0];
                bpc_pkg::REG_DOUBLE_ENABLE: r_cfg.double_enable <= i_cfg_data[0];
                bpc_pkg::REG_LONG_ENABLE:   r_cfg.long_enable   <= i_cfg_data[0];
                default: ;  // unknown index ignored
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_level <= s_axis_tdata[0];
            r_in_now   <= s_axis_tdata[bpc_pkg::TIME_W:1];
        end
    end

    // tracking state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held          <= 1'b0;
            r_press_stamp   <= '0;
            r_release_stamp <= '0;
            r_event_fired   <= 1'b0;
            r_press_count   <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (fire) begin
                r_held          <= n_held;
                r_press_stamp   <= n_press_stamp;
                r_release_stamp <= n_release_stamp;
                r_event_fired   <= n_event_fired;
                r_press_count   <= n_press_count;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_event   <= n_event;
            r_out_pressed <= pressed;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_pressed, r_out_event};

endmodule

@@ rtl/core/bpc_checker.sv @@
// bpc_checker: port-level assertions for button_press_classifier, bound to it
// below; depends on bpc_pkg
module bpc_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [bpc_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    // stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result item changed");

    // an accepted item reaches the output when the sink is ready in the cycle after the accept
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("accepted item did not reach the output");

    // a long press is only reported while the button is pressed
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] == bpc_pkg::EV_LONG) |-> m_axis_tdata[2])
        else $error("long press reported on a released poll");

    // single and double presses are only reported on a released poll
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && ((m_axis_tdata[1:0] == bpc_pkg::EV_SINGLE) ||
                          (m_axis_tdata[1:0] == bpc_pkg::EV_DOUBLE))
        |-> !m_axis_tdata[2])
        else $error("single or double press reported on a pressed poll");

    // reset empties the output
    assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ verif/bpc_poll_checker.sv @@
// bpc_poll_checker: watches the poll and result streams of the button press
// classifier, predicts each result and compares it; depends on bpc_pkg
module bpc_poll_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_poll_valid,
    input  logic                               i_poll_ready,
    input  logic [bpc_pkg::IN_DATA_W-1:0]      i_poll_data,   // [0] pin_level, [32:1] now_ms
    input  logic                               i_res_valid,
    input  logic                               i_res_ready,
    input  logic [bpc_pkg::OUT_DATA_W-1:0]     i_res_data,    // [1:0] event_res, [2] pressed
    output int                                 o_fail_count,
    output int                                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        bpc_pkg::t_event ev;
        logic            pressed;
    } t_poll_result;

    bpc_pkg::t_cfg                   cfg_shadow = bpc_pkg::CFG_RESET;
    logic                            btn_held = 1'b0;
    logic [bpc_pkg::TIME_W-1:0]      press_ms = '0;
    logic [bpc_pkg::TIME_W-1:0]      release_ms = '0;
    logic                            fired = 1'b0;
    logic [1:0]                      presses = '0;
    t_poll_result                    expected_polls[$];
    int                              fails = 0;

    function automatic void clear_tracking();
        btn_held   = 1'b0;
        press_ms   = '0;
        release_ms = '0;
        fired      = 1'b0;
        presses    = '0;
    endfunction

    // next result for one poll; updates the tracked press state
    function automatic t_poll_result classify_poll(logic level,
                                                   logic [bpc_pkg::TIME_W-1:0] now_ms);
        t_poll_result               r;
        logic                       is_down;
        logic [bpc_pkg::TIME_W-1:0] held_for;
        logic [bpc_pkg::TIME_W-1:0] press_len;
        logic [bpc_pkg::TIME_W-1:0] quiet_for;
        is_down   = (level == cfg_shadow.active_high);
        r.ev      = bpc_pkg::EV_NONE;
        r.pressed = is_down;
        if (fired) begin
            if (!is_down) clear_tracking();
        end else if (is_down) begin
            held_for = now_ms - press_ms;
            if (!btn_held) begin
                press_ms   = now_ms;
                release_ms = '0;
                btn_held   = 1'b1;
            end else if (cfg_shadow.long_enable && presses == 2'd0 &&
                         held_for >= bpc_pkg::TIME_W'(cfg_shadow.long_press_ms)) begin
                r.ev  = bpc_pkg::EV_LONG;
                fired = 1'b1;
            end
        end else begin
            if (btn_held) begin
                release_ms = now_ms;
                if (presses < bpc_pkg::COUNT_MAX) presses = presses + 2'd1;
                btn_held = 1'b0;
            end
            press_len = release_ms - press_ms;
            quiet_for = now_ms - release_ms;
            if (presses != 2'd0) begin
                if (press_len <= bpc_pkg::TIME_W'(cfg_shadow.debounce_ms)) begin
                    clear_tracking();
                end else if (cfg_shadow.single_enable &&
                             (!cfg_shadow.double_enable ||
                              quiet_for > bpc_pkg::TIME_W'(cfg_shadow.double_gap_ms))) begin
                    r.ev  = bpc_pkg::EV_SINGLE;
                    fired = 1'b1;
                end else if (cfg_shadow.double_enable && presses >= bpc_pkg::COUNT_MAX) begin
                    r.ev  = bpc_pkg::EV_DOUBLE;
                    fired = 1'b1;
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_poll_result want;
        logic [1:0]   got_ev;
        logic         got_pressed;
        logic         bad;
        if (!i_rst_n) begin
            cfg_shadow = bpc_pkg::CFG_RESET;
            clear_tracking();
            expected_polls.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bpc_pkg::REG_ACTIVE_HIGH:
                        cfg_shadow.active_high   = i_cfg_data[0];
                    bpc_pkg::REG_LONG_PRESS_MS:
                        cfg_shadow.long_press_ms = i_cfg_data[bpc_pkg::LONG_W-1:0];
                    bpc_pkg::REG_DEBOUNCE_MS:
                        cfg_shadow.debounce_ms   = i_cfg_data[bpc_pkg::DEBOUNCE_W-1:0];
                    bpc_pkg::REG_DOUBLE_GAP_MS:
                        cfg_shadow.double_gap_ms = i_cfg_data[bpc_pkg::GAP_W-1:0];
                    bpc_pkg::REG_SINGLE_ENABLE:
                        cfg_shadow.single_enable = i_cfg_data[0];
                    bpc_pkg::REG_DOUBLE_ENABLE:
                        cfg_shadow.double_enable = i_cfg_data[0];
                    bpc_pkg::REG_LONG_ENABLE:
                        cfg_shadow.long_enable   = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                got_ev      = i_res_data[1:0];
                got_pressed = i_res_data[2];
                if (expected_polls.size() == 0) begin
                    fails++;
                    $display("%0t ns: result with none expected: expected nothing, got event %0d pressed %0b",
                             $time, got_ev, got_pressed);
                end else begin
                    want = expected_polls.pop_front();
                    bad  = 1'b0;
                    if (got_ev != want.ev) begin
                        bad = 1'b1;
                        $display("%0t ns: event mismatch: expected %0d, got %0d",
                                 $time, want.ev, got_ev);
                    end
                    if (got_pressed != want.pressed) begin
                        bad = 1'b1;
                        $display("%0t ns: pressed mismatch: expected %0b, got %0b",
                                 $time, want.pressed, got_pressed);
                    end
                    if (bad) fails++;
                end
            end
            if (i_poll_valid && i_poll_ready)
                expected_polls.push_back(classify_poll(i_poll_data[0],
                                                       i_poll_data[bpc_pkg::TIME_W:1]));
        end
        o_fail_count <= fails;
        o_pending    <= expected_polls.size();
    end

endmodule

@@ verif/button_press_classifier_tb.sv @@
// button_press_classifier_tb: drives polls, configuration and result backpressure
// into the button press classifier and gives the verdict; depends on bpc_pkg,
// button_press_classifier and bpc_poll_checker
module button_press_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // index that maps to no register, writes to it must be dropped
    localparam logic [bpc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int unsigned ITEMS_PER_PHASE  = 225;
    localparam int unsigned NUM_PHASES       = 8;
    localparam int unsigned SINK_HOLD_CYCLES = 150;
    localparam int unsigned WATCHDOG_LIMIT   = 3000;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [bpc_pkg::CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [bpc_pkg::CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [bpc_pkg::IN_DATA_W-1:0]    s_axis_tdata = '0;   // [0] pin_level, [32:1] now_ms, rest zero
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [bpc_pkg::OUT_DATA_W-1:0]   m_axis_tdata;        // [1:0] event_res, [2] pressed, rest zero

    int                               fail_count;
    int                               pending;

    // stimulus-side view of the current settings, used only to shape gestures
    bpc_pkg::t_cfg                    cfg_now = bpc_pkg::CFG_RESET;
    logic [bpc_pkg::TIME_W-1:0]       clock_ms = '0;
    int unsigned                      polls_sent = 0;
    bit                               sender_gaps = 1'b1;
    bit                               sink_quiet = 1'b0;
    bit                               sink_hold_req = 1'b0;
    bit                               sink_holding = 1'b0;
    int unsigned                      idle_cycles = 0;

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    button_press_classifier DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    bpc_poll_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_poll_valid (s_axis_tvalid),
        .i_poll_ready (s_axis_tready),
        .i_poll_data  (s_axis_tdata),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // watchdog: too long without any item moving on either side ends the run
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no item moved for %0d cycles", $time, idle_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: random stall bursts, ready stretches, and one long hold-off on request
    initial begin : result_sink
        @(posedge i_clk);
        forever begin
            if (sink_hold_req) begin
                m_axis_tready <= 1'b0;
                sink_holding = 1'b1;
                repeat (SINK_HOLD_CYCLES) @(posedge i_clk);
                sink_hold_req = 1'b0;
            end else if (!sink_quiet && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    // one poll; called at a rising edge, returns at the edge that took it
    task automatic send_poll(input logic level, input logic [bpc_pkg::TIME_W-1:0] now_ms);
        if (sender_gaps && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, now_ms, level};
        do @(posedge i_clk); while (!s_axis_tready);
        polls_sent++;
    endtask

    // stop offering and wait until every poll has its result back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bpc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bpc_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // every register gets written, plus a junk write to an unmapped index
    task automatic apply_cfg(input bpc_pkg::t_cfg c);
        write_reg(bpc_pkg::REG_ACTIVE_HIGH,   {15'd0, c.active_high});
        write_reg(bpc_pkg::REG_LONG_PRESS_MS, c.long_press_ms);
        write_reg(bpc_pkg::REG_DEBOUNCE_MS,   {8'd0, c.debounce_ms});
        write_reg(bpc_pkg::REG_DOUBLE_GAP_MS, c.double_gap_ms);
        write_reg(bpc_pkg::REG_SINGLE_ENABLE, {15'd0, c.single_enable});
        write_reg(bpc_pkg::REG_DOUBLE_ENABLE, {15'd0, c.double_enable});
        write_reg(bpc_pkg::REG_LONG_ENABLE,   {15'd0, c.long_enable});
        write_reg(REG_UNUSED,                 bpc_pkg::CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
        cfg_now = c;
    endtask

    function automatic bpc_pkg::t_cfg phase_cfg(input int unsigned ph);
        bpc_pkg::t_cfg c;
        c.active_high   = 1'($urandom_range(0, 1));
        c.long_press_ms = 16'($urandom_range(0, 1500));
        c.debounce_ms   = 8'($urandom_range(0, 255));
        c.double_gap_ms = 16'($urandom_range(0, 600));
        c.single_enable = 1'b1;
        c.double_enable = 1'b1;
        c.long_enable   = 1'b1;
        case (ph)
            0: c = bpc_pkg::CFG_RESET;
            // every threshold at its low end, active-low pin
            1: begin
                c.active_high   = 1'b0;
                c.long_press_ms = '0;
                c.debounce_ms   = '0;
                c.double_gap_ms = '0;
            end
            // every threshold at its high end
            2: begin
                c.active_high   = 1'b1;
                c.long_press_ms = '1;
                c.debounce_ms   = '1;
                c.double_gap_ms = '1;
            end
            // single press reported right at release
            3: c.double_enable = 1'b0;
            // nothing reported, press count just saturates
            4: {c.single_enable, c.double_enable, c.long_enable} = 3'b000;
            5: {c.single_enable, c.double_enable, c.long_enable} = 3'($urandom_range(0, 7));
            6: ;
            default: c = bpc_pkg::CFG_RESET;
        endcase
        return c;
    endfunction

    // how long the button stays down: around debounce and the long-press limit
    function automatic logic [bpc_pkg::TIME_W-1:0] hold_span();
        logic [bpc_pkg::TIME_W-1:0] deb;
        logic [bpc_pkg::TIME_W-1:0] lng;
        deb = bpc_pkg::TIME_W'(cfg_now.debounce_ms);
        lng = bpc_pkg::TIME_W'(cfg_now.long_press_ms);
        case ($urandom_range(0, 5))
            0: return deb;
            1: return deb + 1;
            2: return $urandom_range(0, deb);
            3: return deb + $urandom_range(1, 400);
            4: return lng + 1;
            default: return lng + $urandom_range(2, 300);
        endcase
    endfunction

    // how long the button stays up: around the double-press gap
    function automatic logic [bpc_pkg::TIME_W-1:0] quiet_span();
        logic [bpc_pkg::TIME_W-1:0] gap;
        gap = bpc_pkg::TIME_W'(cfg_now.double_gap_ms);
        case ($urandom_range(0, 4))
            0: return gap;
            1: return gap + 1;
            2: return gap + 2;
            3: return $urandom_range(0, gap);
            default: return gap + $urandom_range(3, 1500);
        endcase
    endfunction

    // a stretch of one button state lasting span ms, polled a few times;
    // sometimes polled once more right at span-1 to land on the thresholds
    task automatic emit_span(input bit down, input logic [bpc_pkg::TIME_W-1:0] span);
        int unsigned                n;
        logic [bpc_pkg::TIME_W-1:0] stride;
        logic                       lvl;
        n      = $urandom_range(1, 4);
        stride = span / n;
        lvl    = down ? cfg_now.active_high : !cfg_now.active_high;
        for (int unsigned k = 0; k < n; k++)
            send_poll(lvl, clock_ms + k * stride);
        if (span > 1 && $urandom_range(0, 2) == 0)
            send_poll(lvl, clock_ms + span - 1);
        clock_ms = clock_ms + span;
    endtask

    // mostly press/release gestures of one to three taps, some random noise
    task automatic run_gestures(input int unsigned count);
        int unsigned stop_at;
        logic        lvl;
        stop_at = polls_sent + count;
        while (polls_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 1)) clock_ms = $urandom;
                    else clock_ms = clock_ms + $urandom_range(0, 100);
                    lvl = 1'($urandom_range(0, 1));
                    send_poll(lvl, clock_ms);
                end
            end else begin
                // a short released lead-in clears a leftover fired event
                if ($urandom_range(0, 1)) emit_span(1'b0, $urandom_range(0, 20));
                repeat ($urandom_range(1, 3)) begin
                    emit_span(1'b1, hold_span());
                    emit_span(1'b0, quiet_span());
                end
            end
        end
    endtask

    initial begin : stimulus
        logic [bpc_pkg::TIME_W-1:0] t;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed polls at the reset settings (pressed = high, debounce 50,
        // gap 300, long 1000)
        send_poll(1'b0, 32'd0);                       // idle at time zero
        t = 32'hFFFF_FF00;
        send_poll(1'b1, t);                           // press
        send_poll(1'b0, t + 30);                      // bounce, clears
        t = 32'hFFFF_FFF0;
        send_poll(1'b1, t);                           // press just before wrap
        send_poll(1'b1, 32'hFFFF_FFFF);               // still held, all-ones time
        send_poll(1'b0, t + 51);                      // release after wrap
        send_poll(1'b0, t + 51 + 300);                // gap not yet passed
        send_poll(1'b0, t + 51 + 301);                // single press
        send_poll(1'b0, t + 400);                     // released after event, clears
        t = 32'd5000;
        send_poll(1'b1, t);
        send_poll(1'b0, t + 100);
        send_poll(1'b1, t + 200);
        send_poll(1'b0, t + 300);                     // double press on second release
        send_poll(1'b0, t + 310);
        t = 32'd9000;
        send_poll(1'b1, t);
        send_poll(1'b1, t + 999);                     // one short of long press
        send_poll(1'b1, t + 1000);                    // long press
        send_poll(1'b1, t + 1500);                    // held after event, nothing
        send_poll(1'b0, t + 1600);
        t = 32'd20000;
        send_poll(1'b1, t);
        send_poll(1'b0, t + 50);                      // exactly the debounce time
        drain_results();

        for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
            apply_cfg(phase_cfg(ph));
            clock_ms = (ph == 2) ? 32'hFFFF_FFFF - $urandom_range(0, 5000) : $urandom;
            case (ph)
                // hold off the result side while polls keep coming, so the
                // block backs up and stalls its input
                6: begin
                    sink_hold_req = 1'b1;
                    sender_gaps   = 1'b0;
                    while (!sink_holding) @(posedge i_clk);
                    run_gestures(40);
                    sender_gaps = 1'b1;
                    run_gestures(ITEMS_PER_PHASE - 40);
                end
                // pause mid-stream until every result is back
                5: begin
                    run_gestures(ITEMS_PER_PHASE / 2);
                    drain_results();
                    run_gestures(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
                end
                // last phase runs at full rate on both sides
                NUM_PHASES - 1: begin
                    sender_gaps = 1'b0;
                    sink_quiet  = 1'b1;
                    run_gestures(ITEMS_PER_PHASE);
                end
                default: run_gestures(ITEMS_PER_PHASE);
            endcase
            drain_results();
        end

        // two-stage pipeline; wait on so that any stray result can still show up
        repeat (6) @(posedge i_clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/bpc_pkg.sv
rtl/core/button_press_classifier.sv
rtl/core/bpc_checker.sv
verif/bpc_poll_checker.sv
verif/button_press_classifier_tb.sv
